// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the bit packer.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal group must hold while the receiver stalls a pending request.
`define ASSERT_HOLD(label, clk, rst_n, vld, stl, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && stl) |=> (vld && $stable(sig))) else $error(msg);

`endif

// ----- rtl/hcbp_pkg.sv -----
// Shared types and constants of the Huffman code bit packer.
// Used by hcbp_front, hcbp_queue, hcbp_back and the top level.
`timescale 1ns / 1ps

package hcbp_pkg;

    localparam int CODE_W = 16;
    localparam int LEN_W  = 5;
    localparam int BYTE_W = 8;
    localparam int PEND_W = 7;
    localparam int PCNT_W = 3;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_ENCODE = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    localparam logic [1:0] JOB_ENC   = 2'd0;
    localparam logic [1:0] JOB_ERR   = 2'd1;
    localparam logic [1:0] JOB_FLUSH = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]        kind;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_job;

endpackage

// ----- rtl/hcbp_front.sv -----
// Front end: accepts requests, holds the code table, classifies encode and flush.
// Depends on hcbp_pkg.
`timescale 1ns / 1ps

module hcbp_front #(
    parameter int MAX_CODE_LEN = 16,
    parameter int NUM_SYMBOLS  = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_command,
    input  logic [7:0]                  i_symbol,
    input  logic [hcbp_pkg::CODE_W-1:0] i_code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]  i_code_length,
    output logic                        o_push,
    output hcbp_pkg::t_job              o_job,
    input  logic                        i_q_full
);

    localparam int IDX_W = $clog2(NUM_SYMBOLS);
    localparam int LIMIT = (MAX_CODE_LEN < 16) ? MAX_CODE_LEN : 16;
    localparam logic [hcbp_pkg::LEN_W-1:0] LEN_LIMIT = hcbp_pkg::LEN_W'(LIMIT);

    logic [hcbp_pkg::CODE_W-1:0] r_code_mem [NUM_SYMBOLS];
    logic [hcbp_pkg::LEN_W-1:0]  r_len_mem  [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0]      r_entry_valid;
    logic [hcbp_pkg::CODE_W-1:0] r_rd_code;
    logic [hcbp_pkg::LEN_W-1:0]  r_rd_len;
    logic                        r_st_valid;
    logic [1:0]                  r_st_kind;

    logic                        accept;
    logic                        in_table;
    logic [IDX_W-1:0]            idx;
    logic [hcbp_pkg::LEN_W-1:0]  len_sat;
    logic [hcbp_pkg::CODE_W:0]   mask;
    logic                        do_write;
    logic                        do_job;
    logic [1:0]                  n_kind;

    assign o_stall  = r_st_valid && i_q_full;
    assign accept   = i_valid && !o_stall;
    assign o_push   = r_st_valid && !i_q_full;
    assign in_table = {1'b0, i_symbol} < 9'(NUM_SYMBOLS);
    assign idx      = i_symbol[IDX_W-1:0];
    assign len_sat  = (i_code_length > LEN_LIMIT) ? LEN_LIMIT : i_code_length;
    assign mask     = ((hcbp_pkg::CODE_W+1)'(1) << len_sat) - (hcbp_pkg::CODE_W+1)'(1);
    assign do_write = accept && (i_command == hcbp_pkg::CMD_WRITE) && in_table;
    assign do_job   = accept && ((i_command == hcbp_pkg::CMD_ENCODE) ||
                                 (i_command == hcbp_pkg::CMD_FLUSH));

    always_comb begin
        case (i_command)
            hcbp_pkg::CMD_ENCODE: begin
                n_kind = (in_table && r_entry_valid[idx]) ? hcbp_pkg::JOB_ENC
                                                          : hcbp_pkg::JOB_ERR;
            end
            default: begin
                n_kind = hcbp_pkg::JOB_FLUSH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_code_mem[idx] <= i_code_bits & mask[hcbp_pkg::CODE_W-1:0];
            r_len_mem[idx]  <= len_sat;
        end
        if (accept && (i_command == hcbp_pkg::CMD_ENCODE)) begin
            r_rd_code <= r_code_mem[idx];
            r_rd_len  <= r_len_mem[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
            r_st_valid    <= 1'b0;
            r_st_kind     <= hcbp_pkg::JOB_FLUSH;
        end else begin
            if (do_write) begin
                r_entry_valid[idx] <= 1'b1;
            end
            if (do_job) begin
                r_st_valid <= 1'b1;
                r_st_kind  <= n_kind;
            end else if (o_push) begin
                r_st_valid <= 1'b0;
            end
        end
    end

    assign o_job.kind = r_st_kind;
    assign o_job.code = r_rd_code;
    assign o_job.len  = r_rd_len;

endmodule

// ----- rtl/hcbp_queue.sv -----
// Short job queue between the front and back ends.
// Depends on hcbp_pkg.
`timescale 1ns / 1ps

module hcbp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hcbp_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    output hcbp_pkg::t_job o_job,
    input  logic           i_pop
);

    localparam logic [hcbp_pkg::Q_PTR_W-1:0] LAST_PTR =
        hcbp_pkg::Q_PTR_W'(hcbp_pkg::QUEUE_DEPTH - 1);
    localparam logic [hcbp_pkg::Q_CNT_W-1:0] FULL_CNT =
        hcbp_pkg::Q_CNT_W'(hcbp_pkg::QUEUE_DEPTH);

    hcbp_pkg::t_job                r_slot [hcbp_pkg::QUEUE_DEPTH];
    logic [hcbp_pkg::Q_PTR_W-1:0]  r_wr_ptr;
    logic [hcbp_pkg::Q_PTR_W-1:0]  r_rd_ptr;
    logic [hcbp_pkg::Q_CNT_W-1:0]  r_count;
    logic                          push_ok;
    logic                          pop_ok;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_job   = r_slot[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/hcbp_back.sv -----
// Back end: bit accumulator, byte packing and the output register.
// Depends on hcbp_pkg.
`timescale 1ns / 1ps

module hcbp_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  hcbp_pkg::t_job              i_job,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [hcbp_pkg::BYTE_W-1:0] o_packed_byte,
    output logic                        o_last_in_run,
    output logic                        o_status
);

    localparam int ACC_W = hcbp_pkg::PEND_W + hcbp_pkg::CODE_W;

    logic [hcbp_pkg::PEND_W-1:0] r_pend_bits;
    logic [hcbp_pkg::PCNT_W-1:0] r_pend_cnt;
    logic                        r_o_valid;
    logic [hcbp_pkg::BYTE_W-1:0] r_o_byte;
    logic                        r_o_last;
    logic                        r_o_status;
    logic                        r_hold_valid;
    logic [hcbp_pkg::BYTE_W-1:0] r_hold_byte;

    logic                        out_move;
    logic [ACC_W-1:0]            acc;
    logic [hcbp_pkg::LEN_W-1:0]  total;
    logic [hcbp_pkg::LEN_W-1:0]  sh_hi;
    logic [hcbp_pkg::LEN_W-1:0]  sh_lo;
    logic [ACC_W-1:0]            acc_hi;
    logic [ACC_W-1:0]            acc_lo;
    logic [hcbp_pkg::PCNT_W-1:0] cnt_next;
    logic [hcbp_pkg::BYTE_W-1:0] keep_mask;
    logic [hcbp_pkg::BYTE_W-1:0] flush_byte;
    logic [3:0]                  flush_sh;
    logic                        has_one;
    logic                        has_two;

    assign out_move = !r_o_valid || !i_stall;
    assign o_pop    = i_q_valid && !r_hold_valid && out_move;

    assign acc       = (ACC_W'(r_pend_bits) << i_job.len) | ACC_W'(i_job.code);
    assign total     = hcbp_pkg::LEN_W'(r_pend_cnt) + i_job.len;
    assign sh_hi     = total - hcbp_pkg::LEN_W'(8);
    assign sh_lo     = total - hcbp_pkg::LEN_W'(16);
    assign acc_hi    = acc >> sh_hi;
    assign acc_lo    = acc >> sh_lo;
    assign has_one   = (total >= hcbp_pkg::LEN_W'(8));
    assign has_two   = (total >= hcbp_pkg::LEN_W'(16));
    assign cnt_next  = total[hcbp_pkg::PCNT_W-1:0];
    assign keep_mask = (hcbp_pkg::BYTE_W'(1) << cnt_next) - hcbp_pkg::BYTE_W'(1);
    assign flush_sh  = 4'd8 - {1'b0, r_pend_cnt};
    assign flush_byte = {1'b0, r_pend_bits} << flush_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits  <= '0;
            r_pend_cnt   <= '0;
            r_o_valid    <= 1'b0;
            r_hold_valid <= 1'b0;
        end else if (out_move) begin
            if (r_hold_valid) begin
                r_o_valid    <= 1'b1;
                r_hold_valid <= 1'b0;
            end else if (o_pop) begin
                case (i_job.kind)
                    hcbp_pkg::JOB_ENC: begin
                        r_o_valid    <= has_one;
                        r_hold_valid <= has_two;
                        r_pend_cnt   <= cnt_next;
                        r_pend_bits  <= acc[hcbp_pkg::PEND_W-1:0] &
                                        keep_mask[hcbp_pkg::PEND_W-1:0];
                    end
                    hcbp_pkg::JOB_ERR: begin
                        r_o_valid <= 1'b1;
                    end
                    hcbp_pkg::JOB_FLUSH: begin
                        r_o_valid   <= (r_pend_cnt != '0);
                        r_pend_bits <= '0;
                        r_pend_cnt  <= '0;
                    end
                    default: begin
                        r_o_valid <= 1'b0;
                    end
                endcase
            end else begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_move) begin
            if (r_hold_valid) begin
                r_o_byte   <= r_hold_byte;
                r_o_last   <= 1'b1;
                r_o_status <= 1'b0;
            end else if (o_pop) begin
                case (i_job.kind)
                    hcbp_pkg::JOB_ENC: begin
                        r_o_byte    <= acc_hi[hcbp_pkg::BYTE_W-1:0];
                        r_o_last    <= !has_two;
                        r_o_status  <= 1'b0;
                        r_hold_byte <= acc_lo[hcbp_pkg::BYTE_W-1:0];
                    end
                    hcbp_pkg::JOB_ERR: begin
                        r_o_byte   <= '0;
                        r_o_last   <= 1'b1;
                        r_o_status <= 1'b1;
                    end
                    default: begin
                        r_o_byte   <= flush_byte;
                        r_o_last   <= 1'b1;
                        r_o_status <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign o_valid       = r_o_valid;
    assign o_packed_byte = r_o_byte;
    assign o_last_in_run = r_o_last;
    assign o_status      = r_o_status;

endmodule

// ----- rtl/huffman_code_bit_packer_core.sv -----
// Top level of the table-driven Huffman code bit packer.
// Depends on hcbp_pkg, hcbp_front, hcbp_queue and hcbp_back.
//
// Input channel: i_valid / o_stall carries a request of command, symbol,
// code bits and code length. Writes load one table entry and give no result.
// Encodes append the symbol's code to the bit accumulator; flushes emit the
// partial byte padded with zeros. Unknown symbols give one result with status 1.
// Output channel: o_valid / i_stall carries packed bytes; o_last_in_run marks
// the last result of a request.
// Rates: one request per cycle at the input while o_stall is low. The
// output register sends one byte per cycle while i_stall is low, so an
// encode that completes two bytes holds the back end until both are sent;
// the first result passes the table read, the queue and the output register.
// Reset clears the table's valid bits, the accumulator, the queue and the
// output; table contents stay undefined until written.
// A stalled receiver holds the output byte; the queue of two requests keeps
// the input open until it fills.
`timescale 1ns / 1ps

module huffman_code_bit_packer_core #(
    parameter int MAX_CODE_LEN = 16,
    parameter int NUM_SYMBOLS  = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_command,
    input  logic [7:0]                  i_symbol,
    input  logic [hcbp_pkg::CODE_W-1:0] i_code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]  i_code_length,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [hcbp_pkg::BYTE_W-1:0] o_packed_byte,
    output logic                        o_last_in_run,
    output logic                        o_status
);

    logic           push;
    logic           q_full;
    logic           q_valid;
    logic           pop;
    hcbp_pkg::t_job front_job;
    hcbp_pkg::t_job back_job;

    hcbp_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .NUM_SYMBOLS  (NUM_SYMBOLS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_symbol      (i_symbol),
        .i_code_bits   (i_code_bits),
        .i_code_length (i_code_length),
        .o_push        (push),
        .o_job         (front_job),
        .i_q_full      (q_full)
    );

    hcbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (back_job),
        .i_pop   (pop)
    );

    hcbp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_job         (back_job),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_packed_byte (o_packed_byte),
        .o_last_in_run (o_last_in_run),
        .o_status      (o_status)
    );

endmodule

// ----- rtl/hcbp_checker.sv -----
// Port-level checks of the bit packer, bound to the top level.
// Depends on assert_macros.svh and hcbp_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hcbp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [hcbp_pkg::BYTE_W-1:0] o_packed_byte,
    input logic                        o_last_in_run,
    input logic                        o_status
);

    `ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, o_valid, i_stall, o_packed_byte, "output byte changed under stall")
    `ASSERT_CLK(a_err_form, i_clk, i_rst_n, (o_valid && o_status) |-> (o_last_in_run && (o_packed_byte == '0)), "error request malformed")
    `ASSERT_CLK(a_pair_next, i_clk, i_rst_n, (o_valid && !o_last_in_run && !i_stall) |=> (o_valid && !o_status), "second byte of a pair missing")
    `ASSERT_CLK(a_pair_ok, i_clk, i_rst_n, (o_valid && !o_last_in_run) |-> !o_status, "non-final byte flagged as error")

endmodule

bind huffman_code_bit_packer_core hcbp_checker u_hcbp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_packed_byte (o_packed_byte),
    .o_last_in_run (o_last_in_run),
    .o_status      (o_status)
);
